### hw/rtl/transceiver_thermal_scan_unit_defines.svh
// Assertion macros shared by the thermal scan unit modules.
`ifndef TRANSCEIVER_THERMAL_SCAN_UNIT_DEFINES_SVH
`define TRANSCEIVER_THERMAL_SCAN_UNIT_DEFINES_SVH

// Same-cycle implication check
`define TTSU_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttsu check failed");

// Next-cycle implication check
`define TTSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttsu check failed");

`endif

### hw/rtl/ttsu_pkg.sv
package ttsu_pkg;

   // Port range served by the scan
   localparam int PORT_COUNT = 32;
   localparam int PORT_W     = 6;

   // Stream widths
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 64;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 19;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_SHUTDOWN_THRESHOLD = 1'b0;
   localparam csr_index_type CSR_MAC_FALLBACK_TEMP  = 1'b1;

   localparam logic signed [17:0] THRESHOLD_RESET    = 18'sd76000;
   localparam logic signed [18:0] MAC_FALLBACK_RESET = 19'sd95000;

   // Module identifiers
   localparam logic [7:0] ID_CMIS_A = 8'h18;
   localparam logic [7:0] ID_CMIS_B = 8'h19;
   localparam logic [7:0] ID_CMIS_C = 8'h1E;
   localparam logic [7:0] ID_SFF_A  = 8'h0C;
   localparam logic [7:0] ID_SFF_B  = 8'h0D;
   localparam logic [7:0] ID_SFF_C  = 8'h11;
   localparam logic [7:0] ID_SFF_D  = 8'hE1;

   // Flat-memory flags in the status byte
   localparam logic [7:0] FLAT_BIT_CMIS = 8'h80;
   localparam logic [7:0] FLAT_BIT_SFF  = 8'h04;

   // Efuse map
   localparam logic [PORT_W-1:0] EFUSE_PORT_LIMIT = 6'd32;
   localparam logic [PORT_W-1:0] EFUSE_CPLD_SPLIT = 6'd16;
   localparam logic [1:0]        EFUSE_CPLD_LOW   = 2'd1;
   localparam logic [1:0]        EFUSE_CPLD_HIGH  = 2'd2;
   localparam logic [7:0]        EFUSE_REG_LOW    = 8'h15;
   localparam logic [7:0]        EFUSE_REG_HIGH   = 8'h14;

   // Division by 1000 as reciprocal multiply, exact for magnitudes up to 2^18
   localparam int               DIV1000_SHIFT = 28;
   localparam logic [18:0]      DIV1000_MULT  = 19'd268436;
   localparam logic [9:0]       MAC_DEG_LIMIT = 10'd200;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Request payload, last field in the low bits
   typedef struct packed {
      logic [2:0]         pad;
      logic               mac_read_ok;
      logic signed [18:0] mac_temp_milli;
      logic               temp_read_ok;
      logic [15:0]        sff_temp_word;
      logic [15:0]        cmis_temp_word;
      logic [7:0]         status_byte;
      logic [7:0]         id_byte;
      logic               id_read_ok;
      logic               port_present;
      logic [PORT_W-1:0]  port_number;
   } req_type;

   // Result payload, last field in the low bits
   typedef struct packed {
      logic [2:0]         pad;
      logic [PORT_W-1:0]  xcvr_report_port;
      logic signed [7:0]  xcvr_report_deg;
      logic signed [8:0]  mac_report_deg;
      logic [7:0]         efuse_clear_mask;
      logic [7:0]         efuse_register;
      logic [1:0]         efuse_cpld;
      logic               shutdown_request;
      logic               temp_valid;
      logic signed [17:0] port_temp_milli;
   } rsp_type;

   // Classified port reading handed from front to back
   typedef struct packed {
      logic               temp_valid;
      logic signed [17:0] temp_milli;
      logic signed [7:0]  temp_deg;
      logic               shutdown;
      logic [1:0]         efuse_cpld;
      logic [7:0]         efuse_register;
      logic [7:0]         efuse_mask;
      logic [PORT_W-1:0]  port;
      logic               last;
      logic signed [8:0]  mac_deg;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### hw/rtl/ttsu_front.sv
module ttsu_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ttsu_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tlast,
   input  logic                              csr_we,
   input  logic [ttsu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ttsu_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ttsu_pkg::item_type                item
);
   import ttsu_pkg::*;

   logic signed [17:0] threshold_ff, threshold_in;
   logic signed [18:0] mac_fallback_ff, mac_fallback_in;

   req_type            req;
   logic               is_cmis, is_sff, port_ok, valid;
   logic signed [15:0] word;
   logic signed [25:0] word_x;
   logic signed [25:0] prod1000;
   logic signed [25:0] milli_q;
   logic signed [15:0] deg_q;
   logic signed [17:0] temp_milli;
   logic               shut, efuse_mapped;
   logic [PORT_W-1:0]  port_m1;
   logic signed [18:0] mac_sel;
   logic               mac_neg;
   logic [18:0]        mac_mag;
   logic [37:0]        mac_prod;
   logic [9:0]         mac_q;
   logic [7:0]         mac_clamp;
   logic signed [8:0]  mac_deg_abs;

   // Configuration registers
   always_comb begin
      threshold_in    = threshold_ff;
      mac_fallback_in = mac_fallback_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SHUTDOWN_THRESHOLD: threshold_in = csr_wdata[17:0];
            CSR_MAC_FALLBACK_TEMP:  mac_fallback_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         mac_fallback_ff <= MAC_FALLBACK_RESET;
      end else begin
         threshold_ff    <= threshold_in;
         mac_fallback_ff <= mac_fallback_in;
      end
   end

   // Module type decode and validity
   always_comb begin
      req     = req_type'(req_tdata);
      is_cmis = req.id_byte inside {ID_CMIS_A, ID_CMIS_B, ID_CMIS_C};
      is_sff  = req.id_byte inside {ID_SFF_A, ID_SFF_B, ID_SFF_C, ID_SFF_D};
      port_ok = (req.port_number != '0) &&
                ({1'b0, req.port_number} <= 7'(PORT_COUNT));
      valid   = req.port_present && req.id_read_ok && port_ok && req.temp_read_ok &&
                ((is_cmis && ((req.status_byte & FLAT_BIT_CMIS) == '0)) ||
                 (!is_cmis && is_sff && ((req.status_byte & FLAT_BIT_SFF) == '0)));
      word    = is_cmis ? req.cmis_temp_word : req.sff_temp_word;
   end

   // word * 1000 / 256, truncated toward zero; degrees are word / 256
   always_comb begin
      word_x     = 26'(word);
      prod1000   = (word_x <<< 10) - (word_x <<< 4) - (word_x <<< 3);
      milli_q    = (prod1000 >>> 8) +
                   26'(prod1000[25] && (prod1000[7:0] != '0));
      deg_q      = (word >>> 8) + 16'(word[15] && (word[7:0] != '0));
      temp_milli = valid ? milli_q[17:0] : '0;
   end

   // Shutdown and efuse location
   always_comb begin
      shut         = valid && (temp_milli > threshold_ff);
      port_m1      = req.port_number - 6'd1;
      efuse_mapped = shut && (req.port_number != '0) &&
                     (req.port_number <= EFUSE_PORT_LIMIT);
   end

   // MAC degrees: magnitude times reciprocal of 1000, clamped
   always_comb begin
      mac_sel     = req.mac_read_ok ? req.mac_temp_milli : mac_fallback_ff;
      mac_neg     = mac_sel[18];
      mac_mag     = mac_neg ? 19'(-mac_sel) : 19'(mac_sel);
      mac_prod    = 38'(mac_mag) * 38'(DIV1000_MULT);
      mac_q       = mac_prod[DIV1000_SHIFT +: 10];
      mac_clamp   = (mac_q > MAC_DEG_LIMIT) ? MAC_DEG_LIMIT[7:0] : mac_q[7:0];
      mac_deg_abs = $signed({1'b0, mac_clamp});
   end

   // Classified transaction
   always_comb begin
      item.temp_valid     = valid;
      item.temp_milli     = temp_milli;
      item.temp_deg       = deg_q[7:0];
      item.shutdown       = shut;
      item.efuse_cpld     = !efuse_mapped ? 2'd0 :
                            (req.port_number <= EFUSE_CPLD_SPLIT) ? EFUSE_CPLD_LOW :
                            EFUSE_CPLD_HIGH;
      item.efuse_register = !efuse_mapped ? 8'd0 :
                            port_m1[3] ? EFUSE_REG_HIGH : EFUSE_REG_LOW;
      item.efuse_mask     = efuse_mapped ? (8'd1 << port_m1[2:0]) : 8'd0;
      item.port           = req.port_number;
      item.last           = req_tlast;
      item.mac_deg        = !req_tlast ? 9'sd0 : mac_neg ? -mac_deg_abs : mac_deg_abs;
   end

endmodule

### hw/rtl/ttsu_queue.sv
`include "transceiver_thermal_scan_unit_defines.svh"

module ttsu_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ttsu_pkg::item_type          push_data,
   input  logic                        pop,
   output ttsu_pkg::item_type          pop_data,
   output ttsu_pkg::queue_status_type  status
);
   import ttsu_pkg::*;

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      pop_data     = mem_ff[rd_ptr_ff];
   end

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TTSU_ASSERT(a_count_bound, clock, reset, 1'b1, count_ff <= QUEUE_CW'(QUEUE_DEPTH))
   `TTSU_ASSERT(a_pop_not_empty, clock, reset, pop, !status.empty)
   `TTSU_ASSERT_NEXT(a_push_grows, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1)

endmodule

### hw/rtl/ttsu_back.sv
`include "transceiver_thermal_scan_unit_defines.svh"

module ttsu_back (
   input  logic                              clock,
   input  logic                              reset,
   input  ttsu_pkg::item_type                pop_data,
   input  ttsu_pkg::queue_status_type        status,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ttsu_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);
   import ttsu_pkg::*;

   logic signed [17:0] best_temp_ff, best_temp_in;
   logic signed [7:0]  best_deg_ff, best_deg_in;
   logic [PORT_W-1:0]  best_port_ff, best_port_in;
   logic               best_found_ff, best_found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_last_ff, rsp_last_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               take, cand_found;
   logic signed [17:0] cand_temp;
   logic signed [7:0]  cand_deg;
   logic [PORT_W-1:0]  cand_port;

   // Output register frees whenever its transaction is taken
   assign pop = !status.empty && (!rsp_valid_ff || rsp_tready);

   // Hottest-port tracking
   always_comb begin
      take       = pop_data.temp_valid &&
                   (!best_found_ff || (pop_data.temp_milli > best_temp_ff));
      cand_found = best_found_ff || pop_data.temp_valid;
      cand_temp  = take ? pop_data.temp_milli : best_temp_ff;
      cand_deg   = take ? pop_data.temp_deg   : best_deg_ff;
      cand_port  = take ? pop_data.port       : best_port_ff;

      best_found_in = best_found_ff;
      best_temp_in  = best_temp_ff;
      best_deg_in   = best_deg_ff;
      best_port_in  = best_port_ff;
      if (pop) begin
         if (pop_data.last) begin
            best_found_in = 1'b0;
            best_temp_in  = '0;
            best_deg_in   = '0;
            best_port_in  = '0;
         end else begin
            best_found_in = cand_found;
            best_temp_in  = cand_temp;
            best_deg_in   = cand_deg;
            best_port_in  = cand_port;
         end
      end
   end

   // Result assembly
   always_comb begin
      rsp_data_in                  = rsp_data_ff;
      rsp_last_in                  = rsp_last_ff;
      rsp_valid_in                 = rsp_valid_ff && !rsp_tready;
      if (pop) begin
         rsp_valid_in                 = 1'b1;
         rsp_last_in                  = pop_data.last;
         rsp_data_in.pad              = '0;
         rsp_data_in.port_temp_milli  = pop_data.temp_milli;
         rsp_data_in.temp_valid       = pop_data.temp_valid;
         rsp_data_in.shutdown_request = pop_data.shutdown;
         rsp_data_in.efuse_cpld       = pop_data.efuse_cpld;
         rsp_data_in.efuse_register   = pop_data.efuse_register;
         rsp_data_in.efuse_clear_mask = pop_data.efuse_mask;
         rsp_data_in.mac_report_deg   = pop_data.mac_deg;
         rsp_data_in.xcvr_report_deg  = (pop_data.last && cand_found) ? cand_deg : 8'sd0;
         rsp_data_in.xcvr_report_port =
            (pop_data.last && cand_found && (cand_temp != '0)) ? cand_port : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
         best_temp_ff  <= '0;
         best_deg_ff   <= '0;
         best_port_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         best_found_ff <= best_found_in;
         best_temp_ff  <= best_temp_in;
         best_deg_ff   <= best_deg_in;
         best_port_ff  <= best_port_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `TTSU_ASSERT_NEXT(a_scan_clears, clock, reset, pop && pop_data.last, !best_found_ff && best_temp_ff == '0)
   `TTSU_ASSERT(a_shut_has_temp, clock, reset, rsp_valid_ff && rsp_data_ff.shutdown_request, rsp_data_ff.temp_valid)
   `TTSU_ASSERT(a_report_only_last, clock, reset, rsp_valid_ff && !rsp_last_ff, rsp_data_ff.xcvr_report_port == '0 && rsp_data_ff.mac_report_deg == '0)

endmodule

### hw/rtl/transceiver_thermal_scan_unit.sv
// An accepted request transaction is written into the queue; from the queue head it is popped
// into the result register that drives rsp_.
// Throughput: one port per cycle while rsp_ accepts; a four-entry queue decouples classify
// from tracking/report. Back pressure on rsp_ fills the queue and then drops req_tready.
// Reset (synchronous, active high): queue empty, result register empty, hottest-port state
// cleared, shutdown threshold 76000 and MAC fallback 95000 millidegrees.
module transceiver_thermal_scan_unit (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: port_number[5:0], port_present[6], id_read_ok[7], id_byte[15:8],
   //   status_byte[23:16], cmis_temp_word[39:24], sff_temp_word[55:40],
   //   temp_read_ok[56], mac_temp_milli[75:57], mac_read_ok[76], zero[79:77]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ttsu_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tlast,
   // tdata: port_temp_milli[17:0], temp_valid[18], shutdown_request[19],
   //   efuse_cpld[21:20], efuse_register[29:22], efuse_clear_mask[37:30],
   //   mac_report_deg[46:38], xcvr_report_deg[54:47], xcvr_report_port[60:55],
   //   zero[63:61]; tlast carries report_valid
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ttsu_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [ttsu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ttsu_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ttsu_pkg::*;

   item_type          front_item;
   item_type          queue_head;
   queue_status_type  queue_status;
   logic              queue_pop;

   assign req_tready = !queue_status.full;

   // Classify each request transaction
   ttsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item      (front_item)
   );

   // Decoupling queue
   ttsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && req_tready),
      .push_data (front_item),
      .pop       (queue_pop),
      .pop_data  (queue_head),
      .status    (queue_status)
   );

   // Tracking and result output
   ttsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_data   (queue_head),
      .status     (queue_status),
      .pop        (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
